/* hdl/rlpe_pkg.sv */
package rlpe_pkg;

    localparam int VALUE_BYTES_DEF = 8;
    localparam int MAX_BURST       = 10;
    localparam int CNT_W           = $clog2(MAX_BURST + 1);
    localparam int HDR_BYTES       = 9;

    localparam logic [63:0] SHORT_LIMIT = 64'd56;
    localparam logic [7:0]  LONG_OFFSET = 8'd55;
    localparam logic [7:0]  STRING_BASE = 8'h80;
    localparam logic [7:0]  LIST_BASE   = 8'hc0;

    typedef enum logic [1:0] {
        OP_INT  = 2'd0,
        OP_STR  = 2'd1,
        OP_LIST = 2'd2
    } op_t;

    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } burst_t;

endpackage

/* hdl/rlpe_burst.sv */
module rlpe_burst
    import rlpe_pkg::*;
#(
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
)
(
    input  logic [1:0]  operation,
    input  logic [63:0] value,
    input  logic [63:0] payload_length,
    input  logic [7:0]  data_byte,
    input  logic        first_of_string,
    output burst_t      burst
);

    localparam logic [63:0] VAL_MASK = {64{1'b1}} >> (64 - 8 * VALUE_BYTES);

    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } hdr_t;

    function automatic logic [3:0] sig_bytes(input logic [63:0] x);
        logic [3:0] nb;
        nb = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (x[8*i +: 8] != 8'd0)
            begin
                nb = 4'(i + 1);
            end
        end
        return nb;
    endfunction

    // top-align the significant bytes so they can be read out msb first
    function automatic logic [63:0] top_align(input logic [63:0] x, input logic [3:0] nb);
        logic [6:0] sa;
        sa = {1'b0, 3'(4'd8 - nb), 3'b000};
        if (nb == 4'd8)
        begin
            sa = 7'd0;
        end
        return x << sa;
    endfunction

    function automatic hdr_t len_header(input logic [63:0] len, input logic [7:0] base);
        hdr_t       h;
        logic [3:0] nb;
        logic [63:0] al;
        h  = '0;
        nb = sig_bytes(len);
        al = top_align(len, nb);
        if (len < SHORT_LIMIT)
        begin
            h.bytes[0] = base + len[7:0];
            h.count    = CNT_W'(1);
        end
        else
        begin
            h.bytes[0] = base + LONG_OFFSET + {4'b0000, nb};
            for (int i = 0; i < 8; i++)
            begin
                h.bytes[1+i] = al[63-8*i -: 8];
            end
            h.count = CNT_W'(nb) + CNT_W'(1);
        end
        return h;
    endfunction

    logic [63:0] vm;
    logic [3:0]  vn;
    logic [63:0] v_al;
    hdr_t        hdr;

    assign vm   = value & VAL_MASK;
    assign vn   = sig_bytes(vm);
    assign v_al = top_align(vm, vn);

    always_comb
    begin
        burst = '0;
        hdr   = len_header(payload_length,
                           (operation == OP_LIST) ? LIST_BASE : STRING_BASE);
        case (op_t'(operation))
            OP_INT:
            begin
                if (vn == 4'd0)
                begin
                    burst.bytes[0] = STRING_BASE;
                    burst.count    = CNT_W'(1);
                end
                else if (vn == 4'd1 && vm[7:0] < STRING_BASE)
                begin
                    burst.bytes[0] = vm[7:0];
                    burst.count    = CNT_W'(1);
                end
                else
                begin
                    burst.bytes[0] = STRING_BASE + {4'b0000, vn};
                    for (int i = 0; i < 8; i++)
                    begin
                        burst.bytes[1+i] = v_al[63-8*i -: 8];
                    end
                    burst.count = CNT_W'(vn) + CNT_W'(1);
                end
            end
            OP_STR:
            begin
                if (!first_of_string)
                begin
                    burst.bytes[0] = data_byte;
                    burst.count    = CNT_W'(1);
                end
                else if (payload_length == 64'd0)
                begin
                    burst.bytes[0] = STRING_BASE;
                    burst.count    = CNT_W'(1);
                end
                else if (payload_length == 64'd1 && data_byte < STRING_BASE)
                begin
                    burst.bytes[0] = data_byte;
                    burst.count    = CNT_W'(1);
                end
                else
                begin
                    for (int i = 0; i < HDR_BYTES; i++)
                    begin
                        burst.bytes[i] = hdr.bytes[i];
                    end
                    // payload byte follows the header
                    for (int i = 0; i < MAX_BURST; i++)
                    begin
                        if (CNT_W'(i) == hdr.count)
                        begin
                            burst.bytes[i] = data_byte;
                        end
                    end
                    burst.count = hdr.count + CNT_W'(1);
                end
            end
            OP_LIST:
            begin
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    burst.bytes[i] = hdr.bytes[i];
                end
                burst.count = hdr.count;
            end
            default:
            begin
                burst = '0;
            end
        endcase
    end

endmodule

/* hdl/rlp_header_and_integer_encoder_core.sv */
// channel   | dir | tdata                                         | tuser              | tlast
// s_axis    | in  | value, payload_length, data_byte (136 bits)   | operation, first   | -
// m_axis    | out | out_byte (8 bits)                             | -                  | last
//
// An item is registered on transfer, expanded into its byte burst (up to 10 bytes, none
// for the unused operation code) and loaded into the burst register once that is free,
// then shifted out one byte per cycle from the burst register while m_axis_tready is high.
// An item of k result bytes holds the output until all k bytes are taken; single-byte
// items flow at one per cycle while m_axis_tready is high.
// Reset clears the input and burst occupancy; nothing else is cleared.
// Output stalls back up into the input register and then into s_axis_tready.
module rlp_header_and_integer_encoder_core
    import rlpe_pkg::*;
#(
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // value[63:0], payload_length[127:64], data_byte[135:128]
    input  logic [2:0]   s_axis_tuser,  // operation[1:0], first_of_string[2]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // out_byte[7:0]
    output logic         m_axis_tlast
);

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [63:0] value_reg;
    logic [63:0] len_reg;
    logic [7:0]  dbyte_reg;
    logic        first_reg;

    logic [MAX_BURST-1:0][7:0] bst_bytes_reg;
    logic [CNT_W-1:0]          bst_cnt_reg;

    burst_t burst;
    logic   out_xfer;
    logic   bst_free;
    logic   in_load;
    logic   in_xfer;

    rlpe_burst #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_burst (
        .operation       (op_reg),
        .value           (value_reg),
        .payload_length  (len_reg),
        .data_byte       (dbyte_reg),
        .first_of_string (first_reg),
        .burst           (burst)
    );

    assign m_axis_tvalid = (bst_cnt_reg != '0);
    assign m_axis_tdata  = bst_bytes_reg[0];
    assign m_axis_tlast  = (bst_cnt_reg == CNT_W'(1));

    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign bst_free      = !m_axis_tvalid || (out_xfer && m_axis_tlast);
    assign in_load       = in_valid_reg && bst_free;
    assign s_axis_tready = !in_valid_reg || in_load;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            bst_cnt_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (in_load)
            begin
                bst_cnt_reg <= burst.count;
            end
            else if (out_xfer)
            begin
                bst_cnt_reg <= bst_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            value_reg <= s_axis_tdata[63:0];
            len_reg   <= s_axis_tdata[127:64];
            dbyte_reg <= s_axis_tdata[135:128];
            op_reg    <= s_axis_tuser[1:0];
            first_reg <= s_axis_tuser[2];
        end

        if (in_load)
        begin
            bst_bytes_reg <= burst.bytes;
        end
        else if (out_xfer)
        begin
            bst_bytes_reg <= bst_bytes_reg >> 8;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bst_cnt_reg <= CNT_W'(MAX_BURST))
        else $error("burst count beyond maximum");

    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("burst ended before last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_xfer) |-> !in_load)
        else $error("burst overwritten while pending");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_load && burst.count == '0) |=> !m_axis_tvalid)
        else $error("empty item produced output");

endmodule
